@@ design/uctok_pkg.sv @@
// uctok_pkg: shared constants, types and byte classifiers for the
// utf-8 character n-gram tokenizer; used by every design file, depends on nothing
package uctok_pkg;

  // sizes
  localparam int MAX_NGRAM   = 8;
  localparam int SLOT_W      = $clog2(MAX_NGRAM);
  localparam int NGRAM_W     = 4;
  localparam int BYTE_W      = 8;
  localparam int POS_W       = 16;
  localparam int LEN_W       = 6;
  localparam int OFF_W       = 32;
  localparam int SEQ_W       = 3;
  localparam int CONT_W      = 2;

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // reset value of the n-gram size register
  localparam logic [NGRAM_W-1:0] NGRAM_RESET = NGRAM_W'(2);

  // result kinds
  localparam logic KIND_TOKEN   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // byte classes
  localparam logic [BYTE_W-1:0] BYTE_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] BYTE_WS_LO  = 8'h09;
  localparam logic [BYTE_W-1:0] BYTE_WS_HI  = 8'h0D;
  localparam logic [BYTE_W-1:0] LEAD2_START = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_START = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_START = 8'hF0;

  // per-cell control, same for every cell of the chain
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // result queue status
  typedef struct packed {
    logic has_item;
    logic has_room;
  } queue_stat_t;

  // one result transaction
  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] start_pos;
    logic [LEN_W-1:0] token_bytes;
    logic [OFF_W-1:0] word_offset;
    logic [OFF_W-1:0] end_offset;
    logic             last_result;
  } result_t;

  // declared sequence length of a lead byte
  function automatic logic [SEQ_W-1:0] seq_len(input logic [BYTE_W-1:0] b);
    logic [SEQ_W-1:0] len;
    if (b < LEAD2_START) begin
      len = SEQ_W'(1);
    end else if (b < LEAD3_START) begin
      len = SEQ_W'(2);
    end else if (b < LEAD4_START) begin
      len = SEQ_W'(3);
    end else begin
      len = SEQ_W'(4);
    end
    return len;
  endfunction

  // space or tab through carriage return
  function automatic logic is_ws(input logic [BYTE_W-1:0] b);
    return (b == BYTE_SPACE) || ((b >= BYTE_WS_LO) && (b <= BYTE_WS_HI));
  endfunction

endpackage

@@ design/uctok_if.sv @@
// uctok_if: valid/ready channel interfaces for text bytes in and results out
// depends on uctok_pkg

interface uctok_in_if;
  logic                          valid;
  logic                          ready;
  logic [uctok_pkg::BYTE_W-1:0]  text_byte;
  logic                          last_byte;
  logic [uctok_pkg::OFF_W-1:0]   base_offset;

  modport source (output valid, output text_byte, output last_byte,
                  output base_offset, input ready);
  modport sink   (input valid, input text_byte, input last_byte,
                  input base_offset, output ready);
endinterface

interface uctok_out_if;
  logic                          valid;
  logic                          ready;
  logic                          result_kind;
  logic [uctok_pkg::POS_W-1:0]   start_pos;
  logic [uctok_pkg::LEN_W-1:0]   token_bytes;
  logic [uctok_pkg::OFF_W-1:0]   word_offset;
  logic [uctok_pkg::OFF_W-1:0]   end_offset;
  logic                          last_result;

  modport source (output valid, output result_kind, output start_pos,
                  output token_bytes, output word_offset, output end_offset,
                  output last_result, input ready);
  modport sink   (input valid, input result_kind, input start_pos,
                  input token_bytes, input word_offset, input end_offset,
                  input last_result, output ready);
endinterface

@@ design/utf8_char_ngram_tokenizer.sv @@
// utf8_char_ngram_tokenizer: top level, byte decode, chain of lead-position
// cells and result queue; depends on uctok_pkg, uctok_if, uctok_cell, uctok_resq

// Takes UTF-8 bytes and emits a token for every run of ngram_size
// non-whitespace code points, followed by a summary result on the last byte
// of each text. Throughput is one byte per cycle while the queue has room:
// the lead positions shift through a chain of eight cells, so picking a
// token's start is one mux on the chain. Results leave through a four-entry
// queue, one per cycle while the output is ready; the byte channel takes a
// byte while at least two entries are free. A last byte that also closes a
// token (two results) leaves one result more in the queue, so the byte
// channel stalls once three are queued: on output stalls, or when such bytes
// come faster than bytes with no result let the queue drain. ngram_size
// (reset 2) must be written via cfg_we/cfg_wdata only while idle; the block
// does not enforce it. 0 gives no tokens and sizes above eight act as eight.
module utf8_char_ngram_tokenizer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [uctok_pkg::NGRAM_W-1:0]     cfg_wdata,
  uctok_in_if.sink                          in_ch,
  uctok_out_if.source                       out_ch
);

  logic [uctok_pkg::NGRAM_W-1:0]  ngram_size;
  logic [uctok_pkg::POS_W-1:0]    byte_position;
  logic [uctok_pkg::CONT_W-1:0]   continuation_left;
  logic [uctok_pkg::OFF_W-1:0]    offset_counter;
  logic                           text_active;

  logic [uctok_pkg::POS_W-1:0]    cell_pos   [uctok_pkg::MAX_NGRAM];
  logic [uctok_pkg::MAX_NGRAM-1:0] cell_valid;
  uctok_pkg::cell_ctrl_t          cell_ctrl;

  logic                           accept;
  logic                           is_lead;
  logic                           ws;
  logic [uctok_pkg::SEQ_W-1:0]    sl;
  logic                           push_lead;
  logic [uctok_pkg::NGRAM_W-1:0]  n_eff;
  logic [uctok_pkg::NGRAM_W-1:0]  n_m2;
  logic [uctok_pkg::SLOT_W-1:0]   sel;
  logic                           tok_ok;
  logic [uctok_pkg::POS_W-1:0]    start;
  logic [uctok_pkg::POS_W-1:0]    span;
  logic [uctok_pkg::LEN_W-1:0]    tok_bytes;
  logic [uctok_pkg::OFF_W-1:0]    off_cur;
  logic [uctok_pkg::OFF_W-1:0]    off_after;

  uctok_pkg::result_t             tok_res;
  uctok_pkg::result_t             sum_res;
  uctok_pkg::result_t             push_a;
  logic [1:0]                     push_n;
  uctok_pkg::result_t             head_item;
  uctok_pkg::queue_stat_t         q_stat;
  logic                           pop;

  // handshake
  assign in_ch.ready  = q_stat.has_room;
  assign accept       = in_ch.valid & in_ch.ready;
  assign out_ch.valid = q_stat.has_item;
  assign pop          = out_ch.valid & out_ch.ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ngram_size <= uctok_pkg::NGRAM_RESET;
    end else if (cfg_we) begin
      ngram_size <= cfg_wdata;
    end
  end

  // byte decode
  assign is_lead   = (continuation_left == '0);
  assign ws        = uctok_pkg::is_ws(in_ch.text_byte);
  assign sl        = uctok_pkg::seq_len(in_ch.text_byte);
  assign push_lead = accept & is_lead & ~ws;

  // token check on the chain: after the shift, cell n-1 holds the start
  assign n_eff = (ngram_size > uctok_pkg::NGRAM_W'(uctok_pkg::MAX_NGRAM))
               ? uctok_pkg::NGRAM_W'(uctok_pkg::MAX_NGRAM) : ngram_size;
  assign n_m2  = n_eff - uctok_pkg::NGRAM_W'(2);
  assign sel   = n_m2[uctok_pkg::SLOT_W-1:0];
  assign tok_ok = push_lead && (n_eff != '0)
               && ((n_eff == uctok_pkg::NGRAM_W'(1)) || cell_valid[sel]);
  assign start = (n_eff == uctok_pkg::NGRAM_W'(1)) ? byte_position : cell_pos[sel];

  // token length and offsets, all modulo their widths
  assign span      = byte_position - start;
  assign tok_bytes = span[uctok_pkg::LEN_W-1:0] + uctok_pkg::LEN_W'(sl);
  assign off_cur   = text_active ? offset_counter : in_ch.base_offset;
  assign off_after = off_cur + uctok_pkg::OFF_W'(tok_ok);

  // result build
  always_comb begin
    tok_res.kind        = uctok_pkg::KIND_TOKEN;
    tok_res.start_pos   = start;
    tok_res.token_bytes = tok_bytes;
    tok_res.word_offset = off_cur;
    tok_res.end_offset  = off_cur + uctok_pkg::OFF_W'(tok_bytes);
    tok_res.last_result = ~in_ch.last_byte;

    sum_res.kind        = uctok_pkg::KIND_SUMMARY;
    sum_res.start_pos   = '0;
    sum_res.token_bytes = '0;
    sum_res.word_offset = off_after;
    sum_res.end_offset  = off_after;
    sum_res.last_result = 1'b1;
  end

  assign push_a = tok_ok ? tok_res : sum_res;
  assign push_n = accept ? (2'(tok_ok) + 2'(in_ch.last_byte)) : 2'd0;

  // per-text state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      continuation_left <= '0;
      offset_counter    <= '0;
      text_active       <= 1'b0;
    end else if (accept) begin
      offset_counter <= off_after;
      text_active    <= ~in_ch.last_byte;
      if (in_ch.last_byte) begin
        byte_position     <= '0;
        continuation_left <= '0;
      end else begin
        byte_position <= byte_position + uctok_pkg::POS_W'(1);
        if (is_lead) begin
          continuation_left <= uctok_pkg::CONT_W'(sl - uctok_pkg::SEQ_W'(1));
        end else begin
          continuation_left <= continuation_left - uctok_pkg::CONT_W'(1);
        end
      end
    end
  end

  // chain control: whitespace or end of text clears the clean run
  assign cell_ctrl.shift = push_lead;
  assign cell_ctrl.clear = accept & (in_ch.last_byte | (is_lead & ws));

  // chain of lead-position cells, newest lead in cell zero
  for (genvar k = 0; k < uctok_pkg::MAX_NGRAM; k++) begin : g_cell
    if (k == 0) begin : g_head
      uctok_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (cell_ctrl),
        .pos_in   (byte_position),
        .valid_in (1'b1),
        .pos      (cell_pos[k]),
        .valid    (cell_valid[k])
      );
    end else begin : g_body
      uctok_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (cell_ctrl),
        .pos_in   (cell_pos[k-1]),
        .valid_in (cell_valid[k-1]),
        .pos      (cell_pos[k]),
        .valid    (cell_valid[k])
      );
    end
  end

  // result queue
  uctok_resq u_resq (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_a    (push_a),
    .push_b    (sum_res),
    .pop       (pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  // output payload
  assign out_ch.result_kind = head_item.kind;
  assign out_ch.start_pos   = head_item.start_pos;
  assign out_ch.token_bytes = head_item.token_bytes;
  assign out_ch.word_offset = head_item.word_offset;
  assign out_ch.end_offset  = head_item.end_offset;
  assign out_ch.last_result = head_item.last_result;

  // clean flags form a thermometer along the chain
  a_chain_thermo: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & ~{cell_valid[uctok_pkg::MAX_NGRAM-2:0], 1'b1}) == '0)
    else $error("clean flags not contiguous along the chain");

  // end of text leaves the decode state cleared
  a_text_end: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.last_byte) |=>
      (byte_position == '0) && (continuation_left == '0) && (cell_valid == '0)
      && !text_active)
    else $error("text state not cleared after last byte");

  // the summary of a text is waiting right after its last byte
  a_summary_ready: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.last_byte) |=> out_ch.valid)
    else $error("no result pending after last byte");

endmodule

@@ design/uctok_cell.sv @@
// uctok_cell: one stage of the lead-position chain, holds a lead byte position
// and a clean flag; depends on uctok_pkg
module uctok_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  uctok_pkg::cell_ctrl_t         ctrl,
  input  logic [uctok_pkg::POS_W-1:0]   pos_in,
  input  logic                          valid_in,
  output logic [uctok_pkg::POS_W-1:0]   pos,
  output logic                          valid
);

  // clean flag: set means this many clean leads in a row
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= valid_in;
    end
  end

  // position handed on from the neighbor
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      pos <= pos_in;
    end
  end

endmodule

@@ design/uctok_resq.sv @@
// uctok_resq: small result queue, takes up to two results per cycle and
// hands one per cycle to the output when popped; depends on uctok_pkg
module uctok_resq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            push_n,
  input  uctok_pkg::result_t    push_a,
  input  uctok_pkg::result_t    push_b,
  input  logic                  pop,
  output uctok_pkg::result_t    head_item,
  output uctok_pkg::queue_stat_t stat
);

  uctok_pkg::result_t                q [uctok_pkg::QUEUE_DEPTH];
  logic [uctok_pkg::QPTR_W-1:0]      head;
  logic [uctok_pkg::QPTR_W-1:0]      tail;
  logic [uctok_pkg::QPTR_W-1:0]      tail_p1;
  logic [uctok_pkg::QCNT_W-1:0]      count;
  logic [uctok_pkg::QCNT_W-1:0]      count_next;

  assign tail_p1    = tail + uctok_pkg::QPTR_W'(1);
  assign count_next = count + uctok_pkg::QCNT_W'(push_n) - uctok_pkg::QCNT_W'(pop);

  // status: room means space for the two results of one byte
  assign stat.has_item = (count != '0);
  assign stat.has_room = (count <= uctok_pkg::QCNT_W'(uctok_pkg::QUEUE_DEPTH - 2));
  assign head_item     = q[head];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        head <= head + uctok_pkg::QPTR_W'(1);
      end
      tail <= tail + uctok_pkg::QPTR_W'(push_n);
    end
  end

  // entry writes
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q[tail] <= push_a;
    end
    if (push_n == 2'd2) begin
      q[tail_p1] <= push_b;
    end
  end

  // pushes only land when the room flag was up
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> stat.has_room)
    else $error("result queue pushed without room");

  // fill count never goes past the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= uctok_pkg::QCNT_W'(uctok_pkg::QUEUE_DEPTH))
    else $error("result queue count out of range");

  // a pop is only issued on a held result
  a_pop_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> stat.has_item)
    else $error("result queue popped while empty");

endmodule
